[hdl/sra_pkg.sv]
// Shared types, constants and helpers for the signed-to-radix ASCII converter.
package sra_pkg;

    localparam int WORD_BITS = 32;
    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int DIG_W     = 6;
    localparam int CNT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int DEPTH_W   = $clog2(WORD_BITS + 1);

    localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] RADIX_DEC = BASE_W'(10);

    localparam logic [DIG_W-1:0]  DIGIT_MAX_DEC = DIG_W'(9);
    localparam logic [DIG_W-1:0]  DIGIT_TEN     = DIG_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] value;
        logic [BASE_W-1:0]           base;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_base;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transfer
        logic step;      // one restoring-division bit
        logic push;      // push remainder digit, restart remainder
        logic out_err;   // load error result
        logic out_sign;  // load '-'
        logic out_pop;   // pop top digit into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_base;  // radix on input port is out of range
        logic div_done;  // current division is on its final bit
        logic quo_zero;  // quotient is zero
        logic neg;       // leading minus needed
        logic one_left;  // one digit left on the stack
    } stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX_DEC) begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[hdl/sra_dpath.sv]
// Datapath: bit-serial divider, digit stack and output register.
module sra_dpath (
    input  logic          aclk,
    input  logic          aresetn,
    input  sra_pkg::in_t  in_data,
    input  sra_pkg::cmd_t cmd,
    output sra_pkg::stat_t stat,
    output sra_pkg::out_t out_data
);

    localparam int W = sra_pkg::WORD_BITS;

    logic [W-1:0]                   quo_reg;
    logic [sra_pkg::DIG_W-1:0]      rem_reg;
    logic [sra_pkg::BASE_W-1:0]     base_reg;
    logic                           neg_reg;
    logic [sra_pkg::CNT_W-1:0]      cnt_reg;
    logic [sra_pkg::DEPTH_W-1:0]    depth_reg;
    logic [sra_pkg::DIG_W-1:0]      stack_reg [W];
    sra_pkg::out_t                  out_reg;

    logic                           in_neg;
    logic [sra_pkg::DIG_W:0]        trial;
    logic [sra_pkg::DIG_W:0]        diff;
    logic                           fits;

    assign in_neg = (in_data.base == sra_pkg::RADIX_DEC) && in_data.value[W-1];

    // partial remainder stays below base, so DIG_W+1 bits hold the trial value
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, base_reg};
    assign fits  = trial >= {1'b0, base_reg};

    always_comb begin
        stat.bad_base = !(in_data.base inside {[sra_pkg::RADIX_MIN:sra_pkg::RADIX_MAX]});
        stat.div_done = cnt_reg == sra_pkg::CNT_W'(W - 1);
        stat.quo_zero = quo_reg == '0;
        stat.neg      = neg_reg;
        stat.one_left = depth_reg == sra_pkg::DEPTH_W'(1);
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            depth_reg <= '0;
        end else begin
            if (cmd.load) begin
                cnt_reg   <= '0;
                depth_reg <= '0;
            end else begin
                if (cmd.step) begin
                    cnt_reg <= stat.div_done ? '0 : cnt_reg + 1'b1;
                end
                if (cmd.push) begin
                    depth_reg <= depth_reg + 1'b1;
                end else if (cmd.out_pop) begin
                    depth_reg <= depth_reg - 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= in_data.base;
            neg_reg  <= in_neg;
            quo_reg  <= in_neg ? W'(-in_data.value) : W'(in_data.value);
            rem_reg  <= '0;
        end else if (cmd.step) begin
            rem_reg <= fits ? diff[sra_pkg::DIG_W-1:0] : trial[sra_pkg::DIG_W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end else if (cmd.push) begin
            rem_reg <= '0;
        end

        // digit stack: push and pop both at entry 0
        if (cmd.push) begin
            stack_reg[0] <= rem_reg;
            for (int i = 1; i < W; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (cmd.out_pop) begin
            for (int i = 0; i < W - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end

        if (cmd.out_err) begin
            out_reg.character <= sra_pkg::CHAR_NUL;
            out_reg.last      <= 1'b1;
            out_reg.bad_base  <= 1'b1;
        end else if (cmd.out_sign) begin
            out_reg.character <= sra_pkg::CHAR_MINUS;
            out_reg.last      <= 1'b0;
            out_reg.bad_base  <= 1'b0;
        end else if (cmd.out_pop) begin
            out_reg.character <= sra_pkg::digit_to_char(stack_reg[0]);
            out_reg.last      <= stat.one_left;
            out_reg.bad_base  <= 1'b0;
        end
    end

    assign out_data = out_reg;

endmodule

[hdl/sra_ctrl.sv]
// Controller: sequences load, division, digit push and character emission.
module sra_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  sra_pkg::stat_t stat,
    output sra_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   slot_free;
    logic   out_load;

    assign slot_free = !m_valid_reg || m_ready;
    assign out_load  = cmd.out_err || cmd.out_sign || cmd.out_pop;
    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.bad_base ? ST_ERR : ST_DIV;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                if (stat.quo_zero) begin
                    state_next = stat.neg ? ST_SIGN : ST_EMIT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    cmd.out_pop = 1'b1;
                    if (stat.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/signed_to_radix_ascii.sv]
// Top level of the signed integer to ASCII radix converter.
//
// Converts one WORD_BITS-bit two's complement value (32 bits) to ASCII digits in
// a radix from 2 to 36, most significant digit first, one character per
// output transfer, with last set on the final character. Digits above nine
// are lower-case letters; zero gives a single '0'. In radix 10 a negative
// value is sent as '-' followed by its magnitude (the most negative value
// included); in any other radix a negative value is printed as its unsigned
// bit pattern. A radix outside 2..36 gives one transfer with character 0,
// last 1 and bad_base 1. One item is handled at a time: s_ready is high only
// while the block is idle. Each digit comes from the bit-serial restoring
// divider (one quotient bit per cycle), whose remainder is then pushed onto
// the digit stack; once the quotient is zero, the optional minus and the
// digits are emitted from the stack, each waiting while the output stalls.
// The output register lets the final character wait for the consumer while
// the next item is accepted.
module signed_to_radix_ascii (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sra_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sra_pkg::out_t m_data
);

    sra_pkg::cmd_t  cmd;
    sra_pkg::stat_t stat;

    // sequencing: idle -> error, or divide/push per digit -> optional sign -> emit
    sra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // divider, digit stack (LSD pushed first, MSD popped first), output reg
    sra_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

    // An error result is always a single, final NUL character.
    a_err_single : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_base |-> m_data.last && (m_data.character == sra_pkg::CHAR_NUL))
        else $error("error result not a final NUL");

    // A regular result never carries a NUL character.
    a_char_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_base |-> m_data.character != sra_pkg::CHAR_NUL)
        else $error("NUL character on regular result");

    // An accepted input transfer always takes the controller out of idle.
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("still ready after input transfer");

    // The datapath never gets a pop and a push in the same cycle.
    a_stack_cmd : assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.out_pop))
        else $error("push and pop together");

endmodule
